@@ rtl/core/ltc_pkg.sv @@
// ltc_pkg: shared types, constants, keyword tables and helpers of the leading token classifier
// no dependencies; used by ltc_char_class, ltc_scanner and leading_token_classifier
`default_nettype none

package ltc_pkg;

   // line and name limits
   localparam int NAME_LIMIT = 32;
   localparam int LINE_LIMIT = 256;

   localparam logic [7:0] NAME_MAX = 8'(NAME_LIMIT - 1);
   localparam logic [7:0] POS_MAX  = 8'(LINE_LIMIT - 1);
   localparam logic [7:0] RUN_MAX  = 8'hFF;

   // token kinds
   localparam logic [5:0] KIND_INCLUDE     = 6'd9;
   localparam logic [5:0] KIND_IDENT       = 6'd14;
   localparam logic [5:0] KIND_NUMBER      = 6'd15;
   localparam logic [5:0] KIND_SYMBOL_BASE = 6'd16;
   localparam logic [5:0] KIND_UNKNOWN     = 6'd35;

   // keyword table: 14 keywords then the include directive
   localparam int KW_COUNT   = 14;
   localparam int KW_ENTRIES = 15;
   localparam int HASH_ENTRY = 14;
   localparam logic [7:0] HASH_LENGTH = 8'd8;
   localparam logic [14:0] ALL_ALIVE = 15'h7FFF;

   localparam logic [7:0] KW_TEXT [KW_ENTRIES][8] = '{
      '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00},
      '{"c", "h", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
      '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
      '{"i", "n", "c", "l", "u", "d", "e", 8'h00},
      '{"d", "e", "f", "i", "n", "e", 8'h00, 8'h00},
      '{"s", "t", "r", "u", "c", "t", 8'h00, 8'h00},
      '{"p", "r", "i", "n", "t", "f", 8'h00, 8'h00},
      '{"s", "c", "a", "n", "f", 8'h00, 8'h00, 8'h00},
      '{"#", "i", "n", "c", "l", "u", "d", "e"}
   };

   localparam logic [3:0] KW_LEN [KW_ENTRIES] = '{
      4'd3, 4'd5, 4'd4, 4'd4, 4'd2, 4'd4, 4'd5, 4'd3,
      4'd6, 4'd7, 4'd6, 4'd6, 4'd6, 4'd5, 4'd8
   };

   // single-character symbols in kind order
   localparam int SYM_COUNT = 19;
   localparam logic [7:0] SYM_CHARS [SYM_COUNT] = '{
      "=", ";", "(", ")", "{", "}", ",", "[", "]", "+",
      "-", "*", "/", "<", ">", "&", "|", "!", "\""
   };

   localparam logic [7:0] CHAR_HASH  = "#";
   localparam logic [7:0] CHAR_UNDER = "_";
   localparam logic [7:0] CHAR_AMP   = "&";
   localparam logic [7:0] CHAR_BAR   = "|";
   localparam logic [7:0] CHAR_BANG  = "!";

   typedef enum logic [1:0] {
      PH_SKIP,
      PH_IN,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      RC_WORD,
      RC_NUMBER,
      RC_HASH,
      RC_UNKNOWN
   } run_class_type;

   typedef struct packed {
      logic       is_space;
      logic       is_alpha;
      logic       is_digit;
      logic       is_under;
      logic       is_hash;
      logic       is_symbol;
      logic       sym_double;
      logic [4:0] sym_index;
   } char_class_type;

   typedef struct packed {
      logic [5:0] kind;
      logic [7:0] start;
      logic [7:0] length;
      logic       too_long;
   } result_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] index;
   } kw_match_type;

   function automatic logic [7:0] sat_inc(input logic [7:0] v, input logic [7:0] lim);
      return (v < lim) ? v + 8'd1 : lim;
   endfunction

   // live keyword whose full length equals the run, lowest index first
   function automatic kw_match_type kw_match(input logic [14:0] alive, input logic [7:0] run);
      kw_match_type m;
      m = '0;
      for (int i = KW_COUNT - 1; i >= 0; i--) begin
         if (alive[i] && ({4'b0, KW_LEN[i]} == run)) begin
            m.hit   = 1'b1;
            m.index = 4'(i);
         end
      end
      return m;
   endfunction

   // keep entries whose next character matches
   function automatic logic [14:0] kw_advance(input logic [14:0] alive, input logic [7:0] run,
                                              input logic [7:0] c);
      logic [14:0] a;
      a = '0;
      for (int i = 0; i < KW_ENTRIES; i++) begin
         a[i] = alive[i] && (run < {4'b0, KW_LEN[i]}) && (KW_TEXT[i][run[2:0]] == c);
      end
      return a;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/leading_token_classifier.sv @@
// result path: a character's transaction lands in the input register, and the line's result is
// registered in the result register; an end-of-line character waits while that register is full
// throughput: one character per cycle otherwise, set by the line-state update in the scanner
// reset: synchronous, active high; empties both registers and returns the line state to
// whitespace skipping at position zero
`default_nettype none

module leading_token_classifier (
   input  wire logic       clock,
   input  wire logic       reset,
   // character channel
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_ch,
   input  wire logic       req_end_of_line,
   // token result channel
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [5:0]      rsp_token_kind,
   output logic [7:0]      rsp_token_start,
   output logic [7:0]      rsp_token_length,
   output logic            rsp_too_long
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_ch_ff;
   logic       in_eol_ff;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   ltc_pkg::result_type rsp_data_ff;

   logic                    req_take;
   logic                    out_free;
   logic                    step_en;
   logic                    res_fire;
   ltc_pkg::char_class_type cls;
   ltc_pkg::result_type     result;

   // the result slot is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;
   // characters without an end-of-line mark never need the result slot
   assign step_en   = in_valid_ff && (!in_eol_ff || out_free);
   assign req_ready = !in_valid_ff || step_en;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take || (in_valid_ff && !step_en);
   assign rsp_valid_in = res_fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload of the input register, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ch_ff  <= req_ch;
         in_eol_ff <= req_end_of_line;
      end
   end

   // character classes for the held character
   ltc_char_class u_char_class (
      .ch  (in_ch_ff),
      .cls (cls)
   );

   // line state and token decision, one character per step
   ltc_scanner u_scanner (
      .clock       (clock),
      .reset       (reset),
      .step_en     (step_en),
      .ch          (in_ch_ff),
      .end_of_line (in_eol_ff),
      .cls         (cls),
      .res_fire    (res_fire),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded once per line
   always_ff @(posedge clock) begin
      if (res_fire) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_token_kind   = rsp_data_ff.kind;
   assign rsp_token_start  = rsp_data_ff.start;
   assign rsp_token_length = rsp_data_ff.length;
   assign rsp_too_long     = rsp_data_ff.too_long;

`ifndef SYNTHESIS
   // a finished line never overwrites a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res_fire |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while occupied");

   // a new result only ever follows an end-of-line step
   a_rsp_from_eol: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(res_fire))
      else $error("result appeared without an end-of-line step");

   // the length flag belongs to identifiers and numbers only
   a_too_long_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_too_long) |->
         (rsp_token_kind == ltc_pkg::KIND_IDENT || rsp_token_kind == ltc_pkg::KIND_NUMBER))
      else $error("too_long set on a kind other than identifier or number");
`endif

endmodule

`default_nettype wire

@@ rtl/core/ltc_char_class.sv @@
// ltc_char_class: character classification for the leading token classifier
// depends on ltc_pkg
`default_nettype none

module ltc_char_class (
   input  wire logic [7:0]           ch,
   output ltc_pkg::char_class_type   cls
);

   logic       sym_hit;
   logic [4:0] sym_idx;

   always_comb begin
      sym_hit = 1'b0;
      sym_idx = '0;
      for (int i = ltc_pkg::SYM_COUNT - 1; i >= 0; i--) begin
         if (ch == ltc_pkg::SYM_CHARS[i]) begin
            sym_hit = 1'b1;
            sym_idx = 5'(i);
         end
      end
   end

   always_comb begin
      cls.is_space   = (ch == 8'd32) || ((ch >= 8'd9) && (ch <= 8'd13));
      cls.is_alpha   = ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));
      cls.is_digit   = (ch >= "0") && (ch <= "9");
      cls.is_under   = (ch == ltc_pkg::CHAR_UNDER);
      cls.is_hash    = (ch == ltc_pkg::CHAR_HASH);
      cls.is_symbol  = sym_hit;
      cls.sym_index  = sym_idx;
      // these report a two-character text without looking ahead
      cls.sym_double = (ch == ltc_pkg::CHAR_AMP) || (ch == ltc_pkg::CHAR_BAR)
                       || (ch == ltc_pkg::CHAR_BANG);
   end

endmodule

`default_nettype wire

@@ rtl/core/ltc_scanner.sv @@
// ltc_scanner: per-line state and single-pass token decision for one character
// depends on ltc_pkg; fed by ltc_char_class
`default_nettype none

module ltc_scanner (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step_en,
   input  wire logic [7:0]               ch,
   input  wire logic                     end_of_line,
   input  wire ltc_pkg::char_class_type  cls,
   output logic                          res_fire,
   output ltc_pkg::result_type           result
);

   ltc_pkg::phase_type     phase_ff, phase_in;
   ltc_pkg::run_class_type class_ff, class_in;
   logic [7:0]             pos_ff, pos_in;
   logic [7:0]             start_ff, start_in;
   logic [14:0]            alive_ff, alive_in;
   logic [7:0]             run_ff, run_in;
   logic [5:0]             kind_ff, kind_in;
   logic [7:0]             len_ff, len_in;
   logic                   long_ff, long_in;

   ltc_pkg::kw_match_type  word_hit;
   ltc_pkg::kw_match_type  end_hit;
   logic                   is_alnum;

   assign is_alnum = cls.is_alpha || cls.is_digit;
   assign res_fire = step_en && end_of_line;

   always_comb begin
      phase_in = phase_ff;
      class_in = class_ff;
      start_in = start_ff;
      alive_in = alive_ff;
      run_in   = run_ff;
      kind_in  = kind_ff;
      len_in   = len_ff;
      long_in  = long_ff;
      pos_in   = ltc_pkg::sat_inc(pos_ff, ltc_pkg::POS_MAX);
      word_hit = '0;
      end_hit  = '0;

      // first non-space character opens the token
      if ((phase_ff == ltc_pkg::PH_SKIP) && !cls.is_space) begin
         start_in = pos_ff;
         run_in   = '0;
         alive_in = ltc_pkg::ALL_ALIVE;
         phase_in = ltc_pkg::PH_IN;
         if (cls.is_hash) begin
            class_in = ltc_pkg::RC_HASH;
         end else if (cls.is_alpha || cls.is_under) begin
            class_in = ltc_pkg::RC_WORD;
         end else if (cls.is_digit) begin
            class_in = ltc_pkg::RC_NUMBER;
         end else begin
            class_in = ltc_pkg::RC_UNKNOWN;
            if (cls.is_symbol) begin
               phase_in = ltc_pkg::PH_DONE;
               kind_in  = ltc_pkg::KIND_SYMBOL_BASE + {1'b0, cls.sym_index};
               len_in   = cls.sym_double ? 8'd2 : 8'd1;
               long_in  = 1'b0;
            end
         end
      end

      // consume the character inside the token
      if (phase_in == ltc_pkg::PH_IN) begin
         word_hit = ltc_pkg::kw_match(alive_in, run_in);
         case (class_in)
            ltc_pkg::RC_WORD: begin
               if (!is_alnum && word_hit.hit) begin
                  phase_in = ltc_pkg::PH_DONE;
                  kind_in  = {2'b0, word_hit.index};
                  len_in   = run_in;
                  long_in  = 1'b0;
               end else if (is_alnum || cls.is_under) begin
                  alive_in = ltc_pkg::kw_advance(alive_in, run_in, ch);
                  run_in   = ltc_pkg::sat_inc(run_in, ltc_pkg::RUN_MAX);
               end else begin
                  phase_in = ltc_pkg::PH_DONE;
                  kind_in  = ltc_pkg::KIND_IDENT;
                  if ({1'b0, run_in} >= 9'(ltc_pkg::NAME_LIMIT)) begin
                     len_in  = ltc_pkg::NAME_MAX;
                     long_in = 1'b1;
                  end else begin
                     len_in  = run_in;
                     long_in = 1'b0;
                  end
               end
            end
            ltc_pkg::RC_NUMBER: begin
               if (cls.is_digit) begin
                  run_in = ltc_pkg::sat_inc(run_in, ltc_pkg::RUN_MAX);
               end else begin
                  phase_in = ltc_pkg::PH_DONE;
                  kind_in  = ltc_pkg::KIND_NUMBER;
                  if ({1'b0, run_in} >= 9'(ltc_pkg::NAME_LIMIT)) begin
                     len_in  = ltc_pkg::NAME_MAX;
                     long_in = 1'b1;
                  end else begin
                     len_in  = run_in;
                     long_in = 1'b0;
                  end
               end
            end
            ltc_pkg::RC_HASH: begin
               if ((run_in < ltc_pkg::HASH_LENGTH)
                   && (ltc_pkg::KW_TEXT[ltc_pkg::HASH_ENTRY][run_in[2:0]] == ch)) begin
                  run_in = ltc_pkg::sat_inc(run_in, ltc_pkg::RUN_MAX);
                  if (run_in == ltc_pkg::HASH_LENGTH) begin
                     phase_in = ltc_pkg::PH_DONE;
                     kind_in  = ltc_pkg::KIND_INCLUDE;
                     len_in   = ltc_pkg::HASH_LENGTH;
                     long_in  = 1'b0;
                  end
               end else begin
                  class_in = ltc_pkg::RC_UNKNOWN;
                  run_in   = ltc_pkg::sat_inc(run_in, ltc_pkg::RUN_MAX);
               end
            end
            default: begin
               run_in = ltc_pkg::sat_inc(run_in, ltc_pkg::RUN_MAX);
            end
         endcase
      end

      // close the line
      if (end_of_line) begin
         if (phase_in == ltc_pkg::PH_SKIP) begin
            start_in = pos_in;
            kind_in  = ltc_pkg::KIND_UNKNOWN;
            len_in   = '0;
            long_in  = 1'b0;
         end else if (phase_in == ltc_pkg::PH_IN) begin
            end_hit = ltc_pkg::kw_match(alive_in, run_in);
            long_in = 1'b0;
            if ((class_in == ltc_pkg::RC_WORD) && end_hit.hit) begin
               kind_in = {2'b0, end_hit.index};
               len_in  = run_in;
            end else if ((class_in == ltc_pkg::RC_WORD)
                         || (class_in == ltc_pkg::RC_NUMBER)) begin
               kind_in = (class_in == ltc_pkg::RC_WORD) ? ltc_pkg::KIND_IDENT
                                                        : ltc_pkg::KIND_NUMBER;
               if ({1'b0, run_in} >= 9'(ltc_pkg::NAME_LIMIT)) begin
                  len_in  = ltc_pkg::NAME_MAX;
                  long_in = 1'b1;
               end else begin
                  len_in  = run_in;
               end
            end else begin
               kind_in = ltc_pkg::KIND_UNKNOWN;
               len_in  = (run_in > ltc_pkg::POS_MAX) ? ltc_pkg::POS_MAX : run_in;
            end
         end
      end

      result.kind     = kind_in;
      result.start    = start_in;
      result.length   = len_in;
      result.too_long = long_in;

      // every line starts from the reset state
      if (end_of_line) begin
         phase_in = ltc_pkg::PH_SKIP;
         class_in = ltc_pkg::RC_WORD;
         pos_in   = '0;
         start_in = '0;
         alive_in = ltc_pkg::ALL_ALIVE;
         run_in   = '0;
         kind_in  = '0;
         len_in   = '0;
         long_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ltc_pkg::PH_SKIP;
         class_ff <= ltc_pkg::RC_WORD;
         pos_ff   <= '0;
         start_ff <= '0;
         alive_ff <= ltc_pkg::ALL_ALIVE;
         run_ff   <= '0;
         kind_ff  <= '0;
         len_ff   <= '0;
         long_ff  <= 1'b0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         class_ff <= class_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         alive_ff <= alive_in;
         run_ff   <= run_in;
         kind_ff  <= kind_in;
         len_ff   <= len_in;
         long_ff  <= long_in;
      end
   end

endmodule

`default_nettype wire
